// ===== rtl/touch_gesture_classifier_defines.svh =====
// Assertion macros shared by the touch gesture classifier RTL.
`ifndef TOUCH_GESTURE_CLASSIFIER_DEFINES_SVH
`define TOUCH_GESTURE_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TGC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("touch gesture classifier check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define TGC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("touch gesture classifier check failed");

`endif

// ===== rtl/tgc_pkg.sv =====
// Types and constants shared by the touch gesture classifier modules.
package tgc_pkg;

	localparam int POS_BITS   = 12;
	localparam int HOLD_BITS  = 16;
	localparam int THR_BITS   = 12;
	localparam int APB_DATA_BITS = 32;
	localparam int APB_ADDR_BITS = 3;

	// Input commands.
	localparam logic [1:0] CMD_TOUCH_DOWN = 2'd0;
	localparam logic [1:0] CMD_TOUCH_UP   = 2'd1;
	localparam logic [1:0] CMD_TICK       = 2'd2;

	// Gesture codes as seen on the result channel.
	localparam logic [1:0] GESTURE_RELEASED = 2'd0;
	localparam logic [1:0] GESTURE_PRESSED  = 2'd1;
	localparam logic [1:0] GESTURE_LONG     = 2'd2;
	localparam logic [1:0] GESTURE_TAP      = 2'd3;

	// Register indexes, taken from paddr[2].
	localparam logic REG_MOVE_THRESHOLD   = 1'b0;
	localparam logic REG_LONG_PRESS_TICKS = 1'b1;

	localparam logic [THR_BITS-1:0]  MOVE_THRESHOLD_RESET   = 12'd10;
	localparam logic [HOLD_BITS-1:0] LONG_PRESS_TICKS_RESET = 16'd500;

	typedef enum logic [3:0] {
		ST_RELEASED = 4'b0001,
		ST_PRESSED  = 4'b0010,
		ST_LONG     = 4'b0100,
		ST_TAP      = 4'b1000
	} gst_t;

	typedef struct packed {
		logic [1:0]           command;
		logic [POS_BITS-1:0]  pos_x;
		logic [POS_BITS-1:0]  pos_y;
		logic [HOLD_BITS-1:0] elapsed_ticks;
	} in_item_t;

	typedef struct packed {
		logic [1:0]          gesture;
		logic                has_moved;
		logic                drag_point_valid;
		logic [POS_BITS-1:0] cursor_x;
		logic [POS_BITS-1:0] cursor_y;
		logic [POS_BITS-1:0] origin_x;
		logic [POS_BITS-1:0] origin_y;
	} out_item_t;

	typedef struct packed {
		logic [THR_BITS-1:0]  move_threshold;
		logic [HOLD_BITS-1:0] long_press_ticks;
	} cfg_t;

	function automatic logic [1:0] gesture_code(gst_t s);
		logic [1:0] code;
		case (s)
			ST_PRESSED: code = GESTURE_PRESSED;
			ST_LONG:    code = GESTURE_LONG;
			ST_TAP:     code = GESTURE_TAP;
			default:    code = GESTURE_RELEASED;
		endcase
		return code;
	endfunction

endpackage

// ===== rtl/touch_gesture_classifier.sv =====
// Touch gesture classifier: one touch contact classified as released, pressed,
// long press or tap.
//
// Items arrive on the item channel (item_valid, item_stall, item) and each gives
// exactly one transaction on the result channel (result_valid, result_stall,
// result) showing the gesture state after that item. An item is taken when
// valid is high and stall is low.
// The item sits in the input register while the state update runs, and the result
// register loads when the result slot is free. Throughput is one item per cycle
// while result_stall is low, since the gesture state registers update as each item
// steps. When result_stall is held, the result register keeps its transaction and
// the input register still takes one more item before item_stall is raised.
// Configuration (move threshold at 0x0, long-press ticks at 0x4) is to be written
// over the APB-style port only while no items are in flight; the block itself does
// not enforce this. Reads return the register.
// Reset is asynchronous and active low: the gesture returns to released, all
// positions and the hold time clear to zero, both channels empty, and the
// registers take their reset values (threshold 10, long press 500 ticks).
module touch_gesture_classifier #(
	parameter int COORD_BITS = 12
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  tgc_pkg::in_item_t                  item,
	output logic                               result_valid,
	input  logic                               result_stall,
	output tgc_pkg::out_item_t                 result,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [tgc_pkg::APB_ADDR_BITS-1:0]  paddr,
	input  logic [tgc_pkg::APB_DATA_BITS-1:0]  pwdata,
	output logic [tgc_pkg::APB_DATA_BITS-1:0]  prdata,
	output logic                               pready
);

	tgc_pkg::cfg_t      cfg;
	logic               valid_s1;
	tgc_pkg::in_item_t  item_s1;
	logic               out_valid_q;
	tgc_pkg::out_item_t result_q;
	tgc_pkg::out_item_t core_result;
	logic               advance, step, accept;

	tgc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tgc_core #(
		.COORD_BITS (COORD_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg),
		.result (core_result)
	);

	// The result slot frees up when empty or when its transaction is taken.
	assign advance    = !out_valid_q || !result_stall;
	assign step       = valid_s1 && advance;
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1    <= accept || (valid_s1 && !step);
			out_valid_q <= step || (out_valid_q && result_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
		if (step) begin
			result_q <= core_result;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = result_q;

endmodule

// ===== rtl/tgc_cfg_regs.sv =====
// Configuration registers of the touch gesture classifier behind an APB-style port.
module tgc_cfg_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [tgc_pkg::APB_ADDR_BITS-1:0]    paddr,
	input  logic [tgc_pkg::APB_DATA_BITS-1:0]    pwdata,
	output logic [tgc_pkg::APB_DATA_BITS-1:0]    prdata,
	output logic                                 pready,
	output tgc_pkg::cfg_t                        cfg
);

	logic          wr_en;
	logic          reg_idx;
	tgc_pkg::cfg_t cfg_q;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.move_threshold   <= tgc_pkg::MOVE_THRESHOLD_RESET;
			cfg_q.long_press_ticks <= tgc_pkg::LONG_PRESS_TICKS_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				tgc_pkg::REG_MOVE_THRESHOLD:
					cfg_q.move_threshold <= pwdata[tgc_pkg::THR_BITS-1:0];
				tgc_pkg::REG_LONG_PRESS_TICKS:
					cfg_q.long_press_ticks <= pwdata[tgc_pkg::HOLD_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			tgc_pkg::REG_MOVE_THRESHOLD:
				prdata = {{(tgc_pkg::APB_DATA_BITS - tgc_pkg::THR_BITS){1'b0}},
					cfg_q.move_threshold};
			tgc_pkg::REG_LONG_PRESS_TICKS:
				prdata = {{(tgc_pkg::APB_DATA_BITS - tgc_pkg::HOLD_BITS){1'b0}},
					cfg_q.long_press_ticks};
			default:
				prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/tgc_core.sv =====
// Gesture state registers and the next-state logic for one transaction.
`include "touch_gesture_classifier_defines.svh"

module tgc_core #(
	parameter int COORD_BITS = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  tgc_pkg::in_item_t    item,
	input  tgc_pkg::cfg_t        cfg,
	output tgc_pkg::out_item_t   result
);

	localparam int PB = tgc_pkg::POS_BITS;
	localparam int HB = tgc_pkg::HOLD_BITS;
	// Compare width covering both the coordinate span and the threshold.
	localparam int DW = (COORD_BITS > tgc_pkg::THR_BITS) ? COORD_BITS : tgc_pkg::THR_BITS;

	tgc_pkg::gst_t         gst_q, gst_n;
	logic                  moved_q, moved_n;
	logic [COORD_BITS-1:0] press_x_q, press_x_n, press_y_q, press_y_n;
	logic [COORD_BITS-1:0] last_x_q, last_x_n, last_y_q, last_y_n;
	logic [HB-1:0]         hold_q, hold_n;

	logic [COORD_BITS-1:0] x, y, dx, dy;
	logic                  beyond;
	logic [HB:0]           hold_sum;
	logic [HB-1:0]         hold_sat;
	logic                  drag;

	assign x = COORD_BITS'(item.pos_x);
	assign y = COORD_BITS'(item.pos_y);
	assign dx = (x > press_x_q) ? (x - press_x_q) : (press_x_q - x);
	assign dy = (y > press_y_q) ? (y - press_y_q) : (press_y_q - y);
	assign beyond = (DW'(dx) > DW'(cfg.move_threshold)) ||
		(DW'(dy) > DW'(cfg.move_threshold));

	assign hold_sum = {1'b0, hold_q} + {1'b0, item.elapsed_ticks};
	assign hold_sat = hold_sum[HB] ? {HB{1'b1}} : hold_sum[HB-1:0];

	always_comb begin
		gst_n     = gst_q;
		moved_n   = moved_q;
		press_x_n = press_x_q;
		press_y_n = press_y_q;
		last_x_n  = last_x_q;
		last_y_n  = last_y_q;
		hold_n    = hold_q;
		drag      = 1'b0;
		case (item.command)
			tgc_pkg::CMD_TOUCH_DOWN: begin
				case (gst_q)
					tgc_pkg::ST_RELEASED: begin
						gst_n     = tgc_pkg::ST_PRESSED;
						moved_n   = 1'b0;
						press_x_n = x;
						press_y_n = y;
					end
					tgc_pkg::ST_PRESSED, tgc_pkg::ST_LONG: begin
						drag = 1'b1;
						if (beyond) begin
							moved_n = 1'b1;
						end
					end
					default: begin
					end
				endcase
				last_x_n = x;
				last_y_n = y;
			end
			tgc_pkg::CMD_TOUCH_UP: begin
				if (gst_q == tgc_pkg::ST_LONG || moved_q) begin
					gst_n = tgc_pkg::ST_RELEASED;
				end else begin
					gst_n = tgc_pkg::ST_TAP;
				end
				hold_n = '0;
			end
			tgc_pkg::CMD_TICK: begin
				if (gst_q == tgc_pkg::ST_PRESSED) begin
					if (!moved_q) begin
						hold_n = hold_sat;
						if (hold_sat >= cfg.long_press_ticks) begin
							gst_n = tgc_pkg::ST_LONG;
						end
					end
				end else if (gst_q == tgc_pkg::ST_TAP) begin
					gst_n = tgc_pkg::ST_RELEASED;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gst_q     <= tgc_pkg::ST_RELEASED;
			moved_q   <= 1'b0;
			press_x_q <= '0;
			press_y_q <= '0;
			last_x_q  <= '0;
			last_y_q  <= '0;
			hold_q    <= '0;
		end else if (step) begin
			gst_q     <= gst_n;
			moved_q   <= moved_n;
			press_x_q <= press_x_n;
			press_y_q <= press_y_n;
			last_x_q  <= last_x_n;
			last_y_q  <= last_y_n;
			hold_q    <= hold_n;
		end
	end

	always_comb begin
		result.gesture          = tgc_pkg::gesture_code(gst_n);
		result.has_moved        = moved_n;
		result.drag_point_valid = drag;
		result.cursor_x         = PB'(last_x_n);
		result.cursor_y         = PB'(last_y_n);
		result.origin_x         = PB'(press_x_n);
		result.origin_y         = PB'(press_y_n);
	end

	`TGC_ASSERT_NOW(a_drag_only_on_touch_down, clk, arst_n,
		step && result.drag_point_valid, item.command == tgc_pkg::CMD_TOUCH_DOWN)
	`TGC_ASSERT_NEXT(a_touch_up_clears_hold, clk, arst_n,
		step && item.command == tgc_pkg::CMD_TOUCH_UP, hold_q == '0)
	`TGC_ASSERT_NEXT(a_new_press_starts_still, clk, arst_n,
		step && item.command == tgc_pkg::CMD_TOUCH_DOWN && gst_q == tgc_pkg::ST_RELEASED,
		!moved_q && gst_q == tgc_pkg::ST_PRESSED)
	`TGC_ASSERT_NEXT(a_moved_press_never_long, clk, arst_n,
		step && item.command == tgc_pkg::CMD_TICK && gst_q == tgc_pkg::ST_PRESSED && moved_q,
		gst_q == tgc_pkg::ST_PRESSED && $stable(hold_q))

endmodule
